FILE: src/assert_macros.svh
// Assertion macros shared by the grid locator RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising clock edge, disabled while reset is high.
`define PTL_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Same, written as antecedent and consequent of an overlapping implication.
`define PTL_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  `PTL_ASSERT(name, clk, rst, (ante) |-> (cons), msg)

`endif

FILE: src/ptl_pkg.sv
// Types, constants and per-axis helper functions for the grid locator.
// No dependencies.
package ptl_pkg;

  // Field and register widths
  localparam int COORD_W   = 32;
  localparam int SIZE_W    = 31;
  localparam int CNT_W     = 13;
  localparam int CELL_W    = 12;
  localparam int IDX_W     = 3;

  // Cell count limit and the divider that follows from it
  localparam int MAX_CELLS = 4096;
  localparam int DIV_STEPS = $clog2(MAX_CELLS) + 1;
  localparam int DEN_W     = SIZE_W + 1;
  localparam int NUM_W     = DEN_W + DIV_STEPS;
  localparam int PROD_W    = DEN_W + SIZE_W;

  // Front stage, product stage, divider steps, clamp, multiply, output
  localparam int LATENCY   = DIV_STEPS + 5;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_SIZE_X   = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_SIZE_Y   = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_CELLS_X  = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_CELLS_Y  = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_CENTER_X = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_CENTER_Y = IDX_W'(5);

  // Front stage result for one axis
  typedef struct packed {
    logic             in;
    logic [DEN_W-1:0] d;
  } front_t;

  // Divider state for one axis: partial remainder, unused numerator bits,
  // quotient bits found so far
  typedef struct packed {
    logic [DEN_W-1:0]     r;
    logic [DIV_STEPS-1:0] low;
    logic [DIV_STEPS-1:0] q;
  } div_axis_t;

  // Cell count limited to MAX_CELLS
  function automatic logic [CNT_W-1:0] sat_cells(logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] lim;
    lim = CNT_W'(MAX_CELLS);
    return (n > lim) ? lim : n;
  endfunction

  // Doubled offset from the lower edge, d = 2*(p - c) + len, and bounds test
  function automatic front_t axis_front(logic [COORD_W-1:0] p, logic [COORD_W-1:0] c,
                                        logic [SIZE_W-1:0] len, logic [CNT_W-1:0] n);
    logic signed [COORD_W:0]   diff;
    logic signed [COORD_W+2:0] dd;
    logic [DEN_W-1:0]          den;
    front_t                    f;
    diff = $signed({p[COORD_W-1], p}) - $signed({c[COORD_W-1], c});
    dd   = $signed({diff[COORD_W], diff, 1'b0}) + $signed((COORD_W + 3)'(len));
    den  = {len, 1'b0};
    f.in = (len != '0) && (n != '0) && !dd[COORD_W+2] &&
           (dd[COORD_W+1:0] <= (COORD_W + 2)'(den));
    f.d  = dd[DEN_W-1:0];
    return f;
  endfunction

  // One restoring division step: one quotient bit
  function automatic div_axis_t div_step(div_axis_t a, logic [DEN_W-1:0] den);
    logic [DEN_W:0] t;
    div_axis_t      s;
    t     = {a.r, a.low[DIV_STEPS-1]};
    s.low = {a.low[DIV_STEPS-2:0], 1'b0};
    if (t >= {1'b0, den}) begin
      s.r = DEN_W'(t - {1'b0, den});
      s.q = {a.q[DIV_STEPS-2:0], 1'b1};
    end else begin
      s.r = t[DEN_W-1:0];
      s.q = {a.q[DIV_STEPS-2:0], 1'b0};
    end
    return s;
  endfunction

endpackage

FILE: src/point_to_grid_triangle_locator.sv
// Uniform grid cell and triangle locator, top level.
// Depends on ptl_pkg and assert_macros.svh.
//
// Usage:
//   Configuration: write wr_data to register wr_index while wr_en is high
//   (0 size_x, 1 size_y, 2 cells_x, 3 cells_y, 4 center_x, 5 center_y).
//   Write only while no item is in flight; items read the registers live.
//   Input: an item (point_x, point_y) is taken at each rising edge with
//   start high and busy low. busy is high only during reset.
//   Output: done strobes for one cycle with inside_res, cell_x, cell_y and
//   triangle; fields other than inside_res are zero for an outside point.
//   The pipeline from accept to the done cycle is one front stage,
//   one multiply stage, 13 divider stages (one quotient bit each, set by
//   the 4096-cell limit), a clamp stage, a remainder multiply stage and the
//   output register. Throughput is one item per cycle while reset is low.
//   Reset clears all valid bits and restores the register defaults
//   (unit grid, one cell, centered at origin). The receiver cannot stall,
//   so results are never held back.
`include "assert_macros.svh"

module point_to_grid_triangle_locator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [ptl_pkg::COORD_W-1:0] point_x,
  input  logic signed [ptl_pkg::COORD_W-1:0] point_y,
  input  logic                              wr_en,
  input  logic [ptl_pkg::IDX_W-1:0]         wr_index,
  input  logic [ptl_pkg::COORD_W-1:0]       wr_data,
  output logic                              done,
  output logic                              inside_res,
  output logic [ptl_pkg::CELL_W-1:0]        cell_x,
  output logic [ptl_pkg::CELL_W-1:0]        cell_y,
  output logic                              triangle
);
  import ptl_pkg::*;

  // Configuration registers
  logic [SIZE_W-1:0]  size_x, size_y;
  logic [CNT_W-1:0]   cells_x, cells_y;
  logic [COORD_W-1:0] center_x, center_y;

  // Derived per-axis constants
  logic [DEN_W-1:0] den_x, den_y;
  logic [CNT_W-1:0] n_x, n_y;

  // Front stage
  logic             s1_valid, s1_in;
  logic [DEN_W-1:0] s1_dx, s1_dy;
  front_t           fx, fy;

  // Divider chain; index 0 is the product stage
  logic      dv_valid [0:DIV_STEPS];
  logic      dv_in    [0:DIV_STEPS];
  div_axis_t dv_x     [0:DIV_STEPS];
  div_axis_t dv_y     [0:DIV_STEPS];
  logic [NUM_W-1:0] num_x, num_y;

  // Clamp stage
  logic              c_valid, c_in;
  logic [CELL_W-1:0] c_cx, c_cy, c_cx_next, c_cy_next;
  logic [DEN_W-1:0]  c_rx, c_ry, c_rx_next, c_ry_next;

  // Remainder multiply stage
  logic              m_valid, m_in;
  logic [CELL_W-1:0] m_cx, m_cy;
  logic [PROD_W-1:0] m_px, m_py;

  assign busy = rst;

  // Configuration write port
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x   <= SIZE_W'(65536);
      size_y   <= SIZE_W'(65536);
      cells_x  <= CNT_W'(1);
      cells_y  <= CNT_W'(1);
      center_x <= '0;
      center_y <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_SIZE_X:   size_x   <= wr_data[SIZE_W-1:0];
        REG_SIZE_Y:   size_y   <= wr_data[SIZE_W-1:0];
        REG_CELLS_X:  cells_x  <= wr_data[CNT_W-1:0];
        REG_CELLS_Y:  cells_y  <= wr_data[CNT_W-1:0];
        REG_CENTER_X: center_x <= wr_data;
        REG_CENTER_Y: center_y <= wr_data;
        default: ;
      endcase
    end
  end

  assign den_x = {size_x, 1'b0};
  assign den_y = {size_y, 1'b0};
  assign n_x   = sat_cells(cells_x);
  assign n_y   = sat_cells(cells_y);

  // Front: doubled offsets and bounds test
  assign fx = axis_front(point_x, center_x, size_x, cells_x);
  assign fy = axis_front(point_y, center_y, size_y, cells_y);

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= start && !busy;
    s1_in <= fx.in && fy.in;
    s1_dx <= fx.d;
    s1_dy <= fy.d;
  end

  // Numerator d*n, loaded into divider form
  assign num_x = NUM_W'(s1_dx) * NUM_W'(n_x);
  assign num_y = NUM_W'(s1_dy) * NUM_W'(n_y);

  // Product stage, then the divider pipeline, one quotient bit per stage
  always_ff @(posedge clk) begin
    if (rst) dv_valid[0] <= 1'b0;
    else     dv_valid[0] <= s1_valid;
    dv_in[0]    <= s1_in;
    dv_x[0].r   <= num_x[NUM_W-1:DIV_STEPS];
    dv_x[0].low <= num_x[DIV_STEPS-1:0];
    dv_x[0].q   <= '0;
    dv_y[0].r   <= num_y[NUM_W-1:DIV_STEPS];
    dv_y[0].low <= num_y[DIV_STEPS-1:0];
    dv_y[0].q   <= '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      if (rst) dv_valid[i+1] <= 1'b0;
      else     dv_valid[i+1] <= dv_valid[i];
      dv_in[i+1] <= dv_in[i];
      dv_x[i+1]  <= div_step(dv_x[i], den_x);
      dv_y[i+1]  <= div_step(dv_y[i], den_y);
    end
  end

  // Upper edge: quotient equals the count, move to last cell, remainder = 2*len
  always_comb begin
    if (dv_x[DIV_STEPS].q >= n_x) begin
      c_cx_next = CELL_W'(n_x - CNT_W'(1));
      c_rx_next = DEN_W'(dv_x[DIV_STEPS].r + den_x);
    end else begin
      c_cx_next = dv_x[DIV_STEPS].q[CELL_W-1:0];
      c_rx_next = dv_x[DIV_STEPS].r;
    end
    if (dv_y[DIV_STEPS].q >= n_y) begin
      c_cy_next = CELL_W'(n_y - CNT_W'(1));
      c_ry_next = DEN_W'(dv_y[DIV_STEPS].r + den_y);
    end else begin
      c_cy_next = dv_y[DIV_STEPS].q[CELL_W-1:0];
      c_ry_next = dv_y[DIV_STEPS].r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else     c_valid <= dv_valid[DIV_STEPS];
    c_in <= dv_in[DIV_STEPS];
    c_cx <= c_cx_next;
    c_cy <= c_cy_next;
    c_rx <= c_rx_next;
    c_ry <= c_ry_next;
  end

  // Cross products for the diagonal test
  always_ff @(posedge clk) begin
    if (rst) m_valid <= 1'b0;
    else     m_valid <= c_valid;
    m_in <= c_in;
    m_cx <= c_cx;
    m_cy <= c_cy;
    m_px <= PROD_W'(c_ry) * PROD_W'(size_x);
    m_py <= PROD_W'(c_rx) * PROD_W'(size_y);
  end

  // Output register; outside points report zeros
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= m_valid;
    inside_res <= m_in;
    cell_x     <= m_in ? m_cx : '0;
    cell_y     <= m_in ? m_cy : '0;
    triangle   <= m_in && (m_px > m_py);
  end

  // Checks
  `PTL_ASSERT_IMPL(a_latency, clk, rst, start && !busy, ##LATENCY done,
    "accepted item did not complete at the fixed latency")
  `PTL_ASSERT_IMPL(a_no_phantom, clk, rst, done, $past(start && !busy, LATENCY),
    "result strobe without a matching accepted item")
  `PTL_ASSERT_IMPL(a_outside_zero, clk, rst, done && !inside_res,
    cell_x == '0 && cell_y == '0 && !triangle,
    "outside point reported nonzero fields")
  `PTL_ASSERT_IMPL(a_rem_range, clk, rst, dv_valid[DIV_STEPS] && dv_in[DIV_STEPS],
    dv_x[DIV_STEPS].r < den_x && dv_y[DIV_STEPS].r < den_y,
    "divider remainder not below divisor")

endmodule

FILE: verif/tb_point_to_grid_triangle_locator.sv
// Testbench for point_to_grid_triangle_locator: directed and random point queries over
// several grid settings, each result checked against an in-bench predictor.
// Depends on ptl_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_point_to_grid_triangle_locator;
  import ptl_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int RESET_CYCLES = 11;
  localparam int REPORT_MAX = 10;
  localparam logic [31:0] COORD_MIN = 32'h8000_0000;
  localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SIZE_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] ONE_Q = 32'h0001_0000;

  // Expected outcome of one point query
  typedef struct {
    logic              in_grid;
    logic [CELL_W-1:0] col;
    logic [CELL_W-1:0] row;
    logic              upper;
  } grid_hit_t;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_index;
  logic [COORD_W-1:0]        wr_data;
  logic                      done;
  logic                      inside_res;
  logic [CELL_W-1:0]         cell_x;
  logic [CELL_W-1:0]         cell_y;
  logic                      triangle;

  point_to_grid_triangle_locator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .point_x(point_x), .point_y(point_y),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .done(done), .inside_res(inside_res), .cell_x(cell_x), .cell_y(cell_y),
    .triangle(triangle)
  );

  // Predictor copy of the grid registers, tracked from the write port
  logic [SIZE_W-1:0]         cfg_size_x, cfg_size_y;
  logic [CNT_W-1:0]          cfg_cells_x, cfg_cells_y;
  logic signed [COORD_W-1:0] cfg_center_x, cfg_center_y;

  // Grid the stimulus aims at, as last written
  logic [SIZE_W-1:0]         plan_sx, plan_sy;
  logic [CNT_W-1:0]          plan_nx, plan_ny;
  logic signed [COORD_W-1:0] plan_cx, plan_cy;
  bit                        plan_equal;

  grid_hit_t hits_due[$];
  int        gap_pct;
  int        fault_count;
  int        idle_run;
  int        items_taken;
  int        results_seen;
  int        grids_applied;
  int        inside_seen;
  int        upper_seen;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One axis: bounds test, cell index and remainder in doubled units
  function automatic bit axis_locate(input logic signed [COORD_W-1:0] p,
                                     input logic signed [COORD_W-1:0] c,
                                     input logic [SIZE_W-1:0] len,
                                     input logic [CNT_W-1:0] cnt,
                                     output longint unsigned cell_idx,
                                     output longint unsigned rem);
    longint            d;
    longint unsigned   n, two_len, num, q;
    cell_idx = 0;
    rem = 0;
    if (len == 0 || cnt == 0) return 1'b0;
    n = (cnt > MAX_CELLS) ? MAX_CELLS : cnt;
    d = 2 * (longint'(p) - longint'(c)) + longint'(len);
    two_len = 2 * longint'(len);
    if (d < 0) return 1'b0;
    if ($unsigned(d) > two_len) return 1'b0;
    num = $unsigned(d) * n;
    q = num / two_len;
    if (q >= n) q = n - 1;
    cell_idx = q;
    rem = num - q * two_len;
    return 1'b1;
  endfunction

  function automatic grid_hit_t predict_hit(input logic signed [COORD_W-1:0] px,
                                            input logic signed [COORD_W-1:0] py);
    grid_hit_t       h;
    longint unsigned ix, iy, rx, ry;
    bit              in_x, in_y;
    in_x = axis_locate(px, cfg_center_x, cfg_size_x, cfg_cells_x, ix, rx);
    in_y = axis_locate(py, cfg_center_y, cfg_size_y, cfg_cells_y, iy, ry);
    h.in_grid = 1'b0;
    h.col = '0;
    h.row = '0;
    h.upper = 1'b0;
    if (in_x && in_y) begin
      h.in_grid = 1'b1;
      h.col = ix[CELL_W-1:0];
      h.row = iy[CELL_W-1:0];
      h.upper = (ry * longint'(cfg_size_x) > rx * longint'(cfg_size_y));
    end
    return h;
  endfunction

  // Monitor: register writes, accepted items and result checks
  always @(posedge clk) begin : monitor
    grid_hit_t want;
    bit        took;
    if (rst) begin
      cfg_size_x = SIZE_W'(65536);
      cfg_size_y = SIZE_W'(65536);
      cfg_cells_x = CNT_W'(1);
      cfg_cells_y = CNT_W'(1);
      cfg_center_x = '0;
      cfg_center_y = '0;
      idle_run = 0;
    end else begin
      took = start && !busy;
      if (wr_en) begin
        case (wr_index)
          REG_SIZE_X:   cfg_size_x = wr_data[SIZE_W-1:0];
          REG_SIZE_Y:   cfg_size_y = wr_data[SIZE_W-1:0];
          REG_CELLS_X:  cfg_cells_x = wr_data[CNT_W-1:0];
          REG_CELLS_Y:  cfg_cells_y = wr_data[CNT_W-1:0];
          REG_CENTER_X: cfg_center_x = wr_data;
          REG_CENTER_Y: cfg_center_y = wr_data;
          default: ;
        endcase
      end
      if (took) begin
        hits_due = {hits_due, predict_hit(point_x, point_y)};
        items_taken++;
      end
      if (done) begin
        results_seen++;
        if (hits_due.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_MAX)
            $display("[%0t] result with no item pending: inside=%0d cell=(%0d,%0d) tri=%0d",
                     $realtime, inside_res, cell_x, cell_y, triangle);
        end else begin
          want = hits_due.pop_front();
          if (want.in_grid) inside_seen++;
          if (want.upper) upper_seen++;
          if (inside_res !== want.in_grid || cell_x !== want.col ||
              cell_y !== want.row || triangle !== want.upper) begin
            fault_count++;
            if (fault_count <= REPORT_MAX)
              $display("[%0t] mismatch: expected inside=%0d cell=(%0d,%0d) tri=%0d, %s%0d %s",
                       $realtime, want.in_grid, want.col, want.row, want.upper,
                       "got inside=", inside_res,
                       $sformatf("cell=(%0d,%0d) tri=%0d", cell_x, cell_y, triangle));
          end
        end
      end
      if (took || done || wr_en) idle_run = 0;
      else idle_run++;
    end
  end

  // Watchdog on cycles with no traffic
  initial begin : watchdog
    @(negedge rst);
    while (idle_run < STALL_LIMIT) @(posedge clk);
    $display("watchdog: %0d cycles with no traffic, %0d results outstanding",
             idle_run, hits_due.size());
    $display("tb_point_to_grid_triangle_locator: FAIL");
    $finish;
  end

  // Offer one item, with a random gap first, and hold it until taken
  task automatic send_point(input logic [31:0] px, input logic [31:0] py);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    point_x <= px;
    point_y <= py;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stop offering items and wait for every pending result
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (hits_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
  endtask

  // Write all six registers once the block is idle
  task automatic apply_grid(input logic [31:0] sx, input logic [31:0] sy,
                            input logic [31:0] nx, input logic [31:0] ny,
                            input logic [31:0] cx, input logic [31:0] cy);
    settle();
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_CELLS_X, nx);
    write_reg(REG_CELLS_Y, ny);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    wr_en <= 1'b0;
    @(posedge clk);
    plan_sx = sx[SIZE_W-1:0];
    plan_sy = sy[SIZE_W-1:0];
    plan_nx = nx[CNT_W-1:0];
    plan_ny = ny[CNT_W-1:0];
    plan_cx = cx;
    plan_cy = cy;
    plan_equal = (sx == sy) && (nx == ny);
    grids_applied++;
  endtask

  // Reset grid: unit square, one cell, centered at the origin
  task automatic test_reset_grid();
    send_point(32'h0, 32'h0);                   // on the diagonal
    send_point(-32'sd32768, -32'sd32768);       // lower-left corner
    send_point(32'sd32768, 32'sd32768);         // upper edge on both axes
    send_point(-32'sd32768, 32'sd32768);        // upper-left corner
    send_point(32'sd32768, -32'sd32768);        // lower-right corner
    send_point(32'sd32769, 32'h0);              // just past x
    send_point(32'h0, -32'sd32769);             // just below y
    send_point(COORD_MAX, COORD_MIN);
    send_point(COORD_MIN, COORD_MAX);
    send_point(32'hFFFF_FFFF, 32'h0);
  endtask

  // 4x4 cells of one unit each, off-origin center; cell borders and edges
  task automatic test_cell_borders();
    logic signed [31:0] cx, cy;
    cx = 32'sd65536;
    cy = -32'sd65536;
    apply_grid(32'd262144, 32'd262144, 32'd4, 32'd4, cx, cy);
    send_point(cx, cy);
    send_point(cx + 32768, cy + 49152);
    send_point(cx + 131072, cy + 131072);
    send_point(cx - 131072, cy + 131071);
    send_point(cx - 131073, cy);
  endtask

  // Zero size, zero count, and counts past the cell limit
  task automatic test_degenerate();
    apply_grid(32'd0, ONE_Q, 32'd1, 32'd1, 32'd0, 32'd0);
    send_point(32'h0, 32'h0);
    apply_grid(ONE_Q, ONE_Q, 32'd1, 32'd0, 32'd0, 32'd0);
    send_point(32'h0, 32'h0);
    apply_grid(ONE_Q, 32'd131072, 32'd8191, 32'd4097, 32'd0, 32'd0);
    send_point(32'sd32768, 32'sd65536);
    send_point(32'sd1, -32'sd65535);
  endtask

  // Widest grid at the coordinate limits, then the narrowest
  task automatic test_extremes();
    apply_grid(SIZE_MAX, SIZE_MAX, 32'd4096, 32'd4096, COORD_MIN, COORD_MAX);
    send_point(COORD_MIN, COORD_MAX);
    send_point(COORD_MIN + 32'h3FFF_FFFF, COORD_MAX - 32'h3FFF_FFFF);
    send_point(COORD_MAX, COORD_MIN);
    send_point(32'h0, 32'h0);
    apply_grid(32'd1, 32'd1, 32'd4096, 32'd4096, 32'd0, 32'd0);
    send_point(32'h0, 32'h0);
  endtask

  function automatic logic [31:0] pick_size(input logic [CNT_W-1:0] cnt);
    int unsigned     r;
    longint unsigned n;
    r = $urandom_range(9);
    n = (cnt == 0) ? 1 : ((cnt > MAX_CELLS) ? MAX_CELLS : cnt);
    case (r)
      0: return 32'd1;
      1: return SIZE_MAX;
      2: return $urandom & SIZE_MAX;
      3, 4, 5: return 32'(n * 2 * $urandom_range(1, 4096));
      default: return $urandom_range(2, 32'h40_0000) & ~32'd1;
    endcase
  endfunction

  function automatic logic [31:0] pick_cells();
    int unsigned r;
    r = $urandom_range(19);
    case (r)
      0: return 32'd1;
      1: return 32'd4096;
      2: return $urandom_range(4097, 8191);
      3: return 32'd0;
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  function automatic logic [31:0] pick_center();
    case ($urandom_range(4))
      0: return 32'd0;
      1: return $urandom;
      2: return COORD_MIN;
      3: return COORD_MAX;
      default: return 32'($signed($urandom_range(0, 32'h20_0000)) - 32'sh10_0000);
    endcase
  endfunction

  // Coordinate along one axis: inside, on a cell border, just outside, or anywhere
  function automatic logic [31:0] pick_coord(input logic signed [31:0] c,
                                             input logic [SIZE_W-1:0] len,
                                             input logic [CNT_W-1:0] cnt);
    int unsigned     mode;
    longint          two_len, d, p, n;
    longint unsigned r;
    mode = $urandom_range(99);
    two_len = 2 * longint'(len);
    n = (cnt == 0) ? 1 : ((cnt > MAX_CELLS) ? MAX_CELLS : cnt);
    r = {$urandom, $urandom};
    if (mode < 60) d = r % (two_len + 1);
    else if (mode < 75) d = (two_len * $urandom_range(int'(n))) / n;
    else if (mode < 85)
      d = $urandom_range(1) ? -64'sd1 - longint'($urandom_range(3)) :
                              two_len + 2 + longint'($urandom_range(3));
    else return $urandom;
    p = longint'(c) + ((d - longint'(len)) >>> 1);
    return p[31:0];
  endfunction

  // Random grids over the sender gap phases
  task automatic test_random_grids();
    int          gaps[3];
    logic [31:0] sx, sy, nx, ny, cx, cy, px, py;
    gaps = '{0, 49, 10};
    for (int ph = 0; ph < 14; ph++) begin
      nx = pick_cells();
      ny = pick_cells();
      sx = pick_size(nx[CNT_W-1:0]);
      sy = pick_size(ny[CNT_W-1:0]);
      cx = pick_center();
      cy = pick_center();
      if ($urandom_range(4) < 2) begin
        ny = nx;
        sy = sx;
      end
      gap_pct = 0;
      apply_grid(sx, sy, nx, ny, cx, cy);
      gap_pct = gaps[ph % 3];
      for (int k = 0; k < 50; k++) begin
        px = pick_coord(plan_cx, plan_sx, plan_nx);
        py = pick_coord(plan_cy, plan_sy, plan_ny);
        // same offset on both axes of a square grid lands on the diagonal
        if (plan_equal && $urandom_range(3) == 0) py = plan_cy + (px - plan_cx);
        send_point(px, py);
      end
    end
    gap_pct = 0;
  endtask

  // Sequence
  initial begin
    rst = 1'b1;
    start = 1'b0;
    point_x = '0;
    point_y = '0;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    gap_pct = 0;
    fault_count = 0;
    items_taken = 0;
    results_seen = 0;
    grids_applied = 0;
    inside_seen = 0;
    upper_seen = 0;
    plan_equal = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_grid();
    test_cell_borders();
    test_degenerate();
    test_extremes();
    test_random_grids();

    settle();
    repeat (LATENCY + 2) @(posedge clk);
    if (hits_due.size() != 0) begin
      fault_count++;
      $display("%0d expected results never arrived", hits_due.size());
    end
    $display("Covered %0d items, %0d results, %0d grid settings after reset.",
             items_taken, results_seen, grids_applied);
    $display("Of those %0d inside the grid, %0d in the upper-left triangle; %0d faults.",
             inside_seen, upper_seen, fault_count);
    if (fault_count == 0) begin
      $display("tb_point_to_grid_triangle_locator: PASS");
    end else begin
      $display("tb_point_to_grid_triangle_locator: FAIL");
    end
    $finish;
  end

endmodule
